FILE: rtl/core/bavg_pkg.sv
// bavg_pkg: shared widths, constants, register codes and the result tag type
// for the 3x3 box mean block; depends on nothing
`default_nettype none

package bavg_pkg;

  // fixed field widths
  localparam int VALUE_BITS  = 16;
  localparam int SIZE_BITS   = 11;
  localparam int IDX_BITS    = 10;
  localparam int ROW_BITS    = 10;
  localparam int COLSUM_BITS = VALUE_BITS + 2;
  localparam int SUM_BITS    = VALUE_BITS + 4;

  // frame size limits and reset size
  localparam int MAX_ROWS   = 1024;
  localparam int MIN_SIZE   = 3;
  localparam logic [SIZE_BITS-1:0] FRAME_SIZE_RESET = 11'd64;

  // divide by nine: q = (sum * ceil(2^23 / 9)) >> 23, exact for sums below 2^21
  localparam int DIV_SHIFT  = 23;
  localparam int RECIP_BITS = 20;
  localparam logic [RECIP_BITS-1:0] RECIP_NINE = 20'd932068;

  // register bus
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  typedef enum logic {
    REG_FRAME_ROWS = 1'b0,
    REG_FRAME_COLS = 1'b1
  } reg_index_t;

  // position and frame-end flag that travel with a result
  typedef struct packed {
    logic [IDX_BITS-1:0] row_index;
    logic [IDX_BITS-1:0] col_index;
    logic                frame_end;
  } res_tag_t;

endpackage

`default_nettype wire

FILE: rtl/core/box_average_3x3_integer.sv
// 3x3 box mean over a raster stream; the accepted beat and the line-store read are
// registered in stage A, then feed the window, sum and divide stages. One input
// beat per cycle sustained while out_stall is low. Stages hold under out_stall and
// bubbles close up, so input keeps flowing while a result waits.
// Reset: frame size 64x64, position counters and all stage valids cleared;
// line stores are not cleared and need no clearing pass.
`default_nettype none

module box_average_3x3_integer #(
  parameter int MAX_COLS = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bavg_pkg::VALUE_BITS-1:0]     cell_value,
  // result stream
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bavg_pkg::VALUE_BITS-1:0]     mean_value,
  output logic [bavg_pkg::IDX_BITS-1:0]       row_index,
  output logic [bavg_pkg::IDX_BITS-1:0]       col_index,
  output logic                                frame_end,
  // register bus
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bavg_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [bavg_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [bavg_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                pready
);
  import bavg_pkg::*;

  localparam int COL_BITS = $clog2(MAX_COLS);
  localparam int LIM_BITS = ($clog2(MAX_COLS + 1) > SIZE_BITS) ?
                            $clog2(MAX_COLS + 1) : SIZE_BITS;

  // configuration
  logic [SIZE_BITS-1:0] frame_rows;
  logic [SIZE_BITS-1:0] frame_cols;
  logic                 cfg_wr;
  reg_index_t           cfg_idx;

  // effective frame size
  logic [SIZE_BITS-1:0] rows_eff;
  logic [SIZE_BITS-1:0] rows_eff_m1;
  logic [ROW_BITS-1:0]  rows_m1;
  logic [LIM_BITS-1:0]  cols_ext;
  logic [LIM_BITS-1:0]  cols_eff;
  logic [LIM_BITS-1:0]  cols_eff_m1;
  logic [COL_BITS-1:0]  cols_m1;

  // position counters
  logic [ROW_BITS-1:0]  row_cnt;
  logic [COL_BITS-1:0]  col_cnt;
  logic [ROW_BITS-1:0]  row_dec;
  logic [COL_BITS-1:0]  col_dec;
  logic                 row_last;
  logic                 col_last;
  logic                 in_accept;

  // stage A: accepted beat and line-store read data
  logic                 a_valid;
  logic                 a_emit;
  logic [VALUE_BITS-1:0] a_cell;
  logic [COL_BITS-1:0]  a_col;
  res_tag_t             a_tag;
  logic [VALUE_BITS-1:0] top_rd;
  logic [VALUE_BITS-1:0] mid_rd;
  logic                 upd_pending;

  // stage B: window updated, stage C: sum ready
  logic                 b_valid;
  res_tag_t             b_tag;
  logic                 c_valid;
  res_tag_t             c_tag;
  logic [SUM_BITS-1:0]  c_sum;

  // flow control
  logic                 out_free;
  logic                 c_free;
  logic                 b_free;
  logic                 a_free;
  logic                 a_move;
  logic                 out_ld;

  // register bus decode
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= FRAME_SIZE_RESET;
      frame_cols <= FRAME_SIZE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_ROWS: frame_rows <= pwdata[SIZE_BITS-1:0];
        REG_FRAME_COLS: frame_cols <= pwdata[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_ROWS: prdata = APB_DATA_BITS'(frame_rows);
      REG_FRAME_COLS: prdata = APB_DATA_BITS'(frame_cols);
      default:        prdata = '0;
    endcase
  end

  // clamp sizes into the supported range
  always_comb begin
    if (frame_rows < SIZE_BITS'(MIN_SIZE)) begin
      rows_eff = SIZE_BITS'(MIN_SIZE);
    end else if (frame_rows > SIZE_BITS'(MAX_ROWS)) begin
      rows_eff = SIZE_BITS'(MAX_ROWS);
    end else begin
      rows_eff = frame_rows;
    end
  end

  assign rows_eff_m1 = rows_eff - 1'b1;
  assign rows_m1     = rows_eff_m1[ROW_BITS-1:0];
  assign cols_ext    = LIM_BITS'(frame_cols);

  always_comb begin
    if (cols_ext < LIM_BITS'(MIN_SIZE)) begin
      cols_eff = LIM_BITS'(MIN_SIZE);
    end else if (cols_ext > LIM_BITS'(MAX_COLS)) begin
      cols_eff = LIM_BITS'(MAX_COLS);
    end else begin
      cols_eff = cols_ext;
    end
  end

  assign cols_eff_m1 = cols_eff - 1'b1;
  assign cols_m1     = cols_eff_m1[COL_BITS-1:0];

  // handshake chain, last stage first
  assign out_free  = !out_valid || !out_stall;
  assign c_free    = !c_valid || out_free;
  assign b_free    = !b_valid || c_free;
  assign a_free    = !a_valid || b_free;
  assign a_move    = a_valid && b_free;
  assign out_ld    = c_valid && out_free;
  assign in_stall  = !a_free;
  assign in_accept = in_valid && !in_stall;

  // raster position of the next beat
  assign row_last = (row_cnt == rows_m1);
  assign col_last = (col_cnt == cols_m1);
  assign row_dec  = row_cnt - 1'b1;
  assign col_dec  = col_cnt - 1'b1;

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (in_accept) begin
      if (col_last) begin
        col_cnt <= '0;
        row_cnt <= row_last ? '0 : row_cnt + 1'b1;
      end else begin
        col_cnt <= col_cnt + 1'b1;
      end
    end
  end

  // line stores: lower written at accept, upper takes the old lower entry in the next cycle
  bavg_line_ram #(
    .DEPTH     (MAX_COLS),
    .ADDR_BITS (COL_BITS)
  ) u_lower (
    .clk   (clk),
    .we    (in_accept),
    .waddr (col_cnt),
    .wdata (cell_value),
    .re    (in_accept),
    .raddr (col_cnt),
    .rdata (mid_rd)
  );

  bavg_line_ram #(
    .DEPTH     (MAX_COLS),
    .ADDR_BITS (COL_BITS)
  ) u_upper (
    .clk   (clk),
    .we    (upd_pending),
    .waddr (a_col),
    .wdata (mid_rd),
    .re    (in_accept),
    .raddr (col_cnt),
    .rdata (top_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      upd_pending <= 1'b0;
    end else begin
      upd_pending <= in_accept;
    end
  end

  // stage A register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_cell          <= cell_value;
      a_col           <= col_cnt;
      a_emit          <= (row_cnt >= ROW_BITS'(2)) && (col_cnt >= COL_BITS'(2));
      a_tag.row_index <= IDX_BITS'(row_dec);
      a_tag.col_index <= IDX_BITS'(col_dec);
      a_tag.frame_end <= row_last && col_last;
    end
  end

  // window and sum
  bavg_window u_window (
    .clk      (clk),
    .shift_en (a_move),
    .sum_en   (b_valid && c_free),
    .top      (top_rd),
    .mid      (mid_rd),
    .cur      (a_cell),
    .sum      (c_sum)
  );

  // stage B: only beats with a result go on
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_move) begin
      b_valid <= a_emit;
    end else if (c_free) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_tag <= a_tag;
    end
  end

  // stage C
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_free) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && c_free) begin
      c_tag <= b_tag;
    end
  end

  // divide and output register
  bavg_div9 u_div9 (
    .clk  (clk),
    .ld   (out_ld),
    .sum  (c_sum),
    .mean (mean_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      row_index <= c_tag.row_index;
      col_index <= c_tag.col_index;
      frame_end <= c_tag.frame_end;
    end
  end

  // checks
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (a_valid && b_valid && c_valid && out_valid && out_stall) |-> in_stall)
    else $error("input taken while every stage is held");

  a_out_drains: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !c_valid) |=> !out_valid)
    else $error("delivered result shown again");

  a_interior_tag: assert property (@(posedge clk) disable iff (rst)
    (a_valid && a_emit) |-> (a_tag.row_index != '0 && a_tag.col_index != '0))
    else $error("result tagged on an edge position");

endmodule

`default_nettype wire

FILE: rtl/core/bavg_line_ram.sv
// bavg_line_ram: one line store, one write port and one registered read port
// depends on bavg_pkg for the value width
`default_nettype none

module bavg_line_ram #(
  parameter int DEPTH     = 1024,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [ADDR_BITS-1:0]            waddr,
  input  logic [bavg_pkg::VALUE_BITS-1:0] wdata,
  input  logic                            re,
  input  logic [ADDR_BITS-1:0]            raddr,
  output logic [bavg_pkg::VALUE_BITS-1:0] rdata
);
  import bavg_pkg::*;

  logic [VALUE_BITS-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bavg_window.sv
// bavg_window: 3x3 window kept as three column sums, plus the registered
// nine-cell sum; depends on bavg_pkg
`default_nettype none

module bavg_window (
  input  logic                            clk,
  input  logic                            shift_en,
  input  logic                            sum_en,
  input  logic [bavg_pkg::VALUE_BITS-1:0] top,
  input  logic [bavg_pkg::VALUE_BITS-1:0] mid,
  input  logic [bavg_pkg::VALUE_BITS-1:0] cur,
  output logic [bavg_pkg::SUM_BITS-1:0]   sum
);
  import bavg_pkg::*;

  logic [COLSUM_BITS-1:0] cs_old;
  logic [COLSUM_BITS-1:0] cs_mid;
  logic [COLSUM_BITS-1:0] cs_new;
  logic [COLSUM_BITS-1:0] colsum_next;

  // sum of the incoming column
  assign colsum_next = COLSUM_BITS'(top) + COLSUM_BITS'(mid) + COLSUM_BITS'(cur);

  // slide the window by one column per beat
  always_ff @(posedge clk) begin
    if (shift_en) begin
      cs_old <= cs_mid;
      cs_mid <= cs_new;
      cs_new <= colsum_next;
    end
  end

  // full window sum
  always_ff @(posedge clk) begin
    if (sum_en) begin
      sum <= SUM_BITS'(cs_old) + SUM_BITS'(cs_mid) + SUM_BITS'(cs_new);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bavg_div9.sv
// bavg_div9: truncating divide by nine through a reciprocal multiply, result
// registered; depends on bavg_pkg
`default_nettype none

module bavg_div9 (
  input  logic                            clk,
  input  logic                            ld,
  input  logic [bavg_pkg::SUM_BITS-1:0]   sum,
  output logic [bavg_pkg::VALUE_BITS-1:0] mean
);
  import bavg_pkg::*;

  logic [SUM_BITS+RECIP_BITS-1:0] prod;

  // scaled reciprocal product
  assign prod = {{RECIP_BITS{1'b0}}, sum} * {{SUM_BITS{1'b0}}, RECIP_NINE};

  always_ff @(posedge clk) begin
    if (ld) begin
      mean <= prod[DIV_SHIFT +: VALUE_BITS];
    end
  end

endmodule

`default_nettype wire
